// ===== rtl/core/ranked_char_list_defines.svh =====
// ranked_char_list_defines.svh: assertion macros used by the ranked_char_list module
// expects clk_i and rst_ni in the scope of every use
`ifndef RANKED_CHAR_LIST_DEFINES_SVH
`define RANKED_CHAR_LIST_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define RCL_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define RCL_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/rcl_pkg.sv =====
// rcl_pkg: sizes, command and status codes and transaction types of the ranked list
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rcl_pkg;

  // storage size and derived widths
  localparam int CAPACITY = 32;
  localparam int AddrW    = $clog2(CAPACITY);
  localparam int CntW     = $clog2(CAPACITY + 1);
  localparam int PosW     = 6;
  localparam int ElemW    = 8;
  localparam int CmpW     = ((PosW > CntW) ? PosW : CntW) + 1;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_GET    = 2'd2,
    CMD_PRINT  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_INVALID = 2'd1,
    STAT_FULL    = 2'd2,
    STAT_EMPTY   = 2'd3
  } status_e;

  // input transaction
  typedef struct packed {
    cmd_e             command;
    logic [PosW-1:0]  position;
    logic [ElemW-1:0] element;
  } item_t;

  // result transaction
  typedef struct packed {
    logic [ElemW-1:0] value;
    status_e          status;
    logic             last;
  } result_t;

  // one write and one read request to the element store
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] waddr;
    logic [ElemW-1:0] wdata;
    logic             re;
    logic [AddrW-1:0] raddr;
  } mem_req_t;

endpackage

`default_nettype wire

// ===== rtl/core/rcl_store.sv =====
// rcl_store: element store of the ranked list, one write and one registered read port
// depends on rcl_pkg
`timescale 1ns / 1ps
`default_nettype none

module rcl_store (
  input  wire logic                     clk_i,
  input  wire rcl_pkg::mem_req_t        req_i,
  output logic [rcl_pkg::ElemW-1:0]     rdata_o
);
  import rcl_pkg::*;

  logic [ElemW-1:0] mem_q [CAPACITY];
  logic [ElemW-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem_q[req_i.waddr] <= req_i.wdata;
    end
    if (req_i.re) begin
      rdata_q <= mem_q[req_i.raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/ranked_char_list.sv =====
// ranked_char_list: top level, command sequencer around the element store
// depends on rcl_pkg, rcl_store and ranked_char_list_defines.svh
`timescale 1ns / 1ps
`default_nettype none
`include "ranked_char_list_defines.svh"

// Ordered list of up to CAPACITY bytes addressed by 1-based position. A command
// is taken when start is high and busy is low. Get, every error and an append
// at position count+1 or a delete of the last entry leave busy low; get answers
// in the cycle after it is taken. An add or delete that moves entries keeps
// busy high while each moved entry passes once through the element store, which
// has one read and one write port. Print streams count results on consecutive
// cycles, one store read each. Results appear for exactly one cycle with
// res_valid_o and cannot be held off; a successful add or delete gives none.
module ranked_char_list (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire rcl_pkg::item_t   item_i,
  output logic                  res_valid_o,
  output rcl_pkg::result_t      res_o
);
  import rcl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SHIFT,
    S_PRINT
  } state_e;

  state_e           state_q, state_d;
  logic [CntW-1:0]  count_q, count_d;
  logic [AddrW-1:0] cur_q, cur_d;
  logic [AddrW-1:0] stop_q, stop_d;
  logic [AddrW-1:0] src_q, src_d;
  logic [AddrW-1:0] ins_q, ins_d;
  logic [ElemW-1:0] elem_q, elem_d;
  logic             dir_up_q, dir_up_d;
  logic             reading_q, reading_d;
  logic             pend_q, pend_d;
  logic             res_valid_q, res_valid_d;
  logic             res_mem_q, res_mem_d;
  status_e          res_status_q, res_status_d;
  logic             res_last_q, res_last_d;

  mem_req_t         mem_req;
  logic [ElemW-1:0] rdata;

  logic             accept;
  logic [CmpW-1:0]  pos_ext;
  logic [CmpW-1:0]  cnt_ext;
  logic             pos_zero;
  logic             add_bad;
  logic             rng_bad;
  logic             full;
  logic [AddrW-1:0] pos_idx;
  logic [AddrW-1:0] last_idx;

  rcl_store u_store (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // position checks against the current fill
  assign accept   = start && !busy;
  assign pos_ext  = CmpW'(item_i.position);
  assign cnt_ext  = CmpW'(count_q);
  assign pos_zero = (item_i.position == '0);
  assign add_bad  = pos_zero || (pos_ext > (cnt_ext + CmpW'(1)));
  assign rng_bad  = pos_zero || (pos_ext > cnt_ext);
  assign full     = (count_q == CntW'(CAPACITY));
  assign pos_idx  = AddrW'(item_i.position - PosW'(1));
  assign last_idx = AddrW'(count_q - CntW'(1));

  // sequencer next state and store requests
  always_comb begin
    state_d      = state_q;
    count_d      = count_q;
    cur_d        = cur_q;
    stop_d       = stop_q;
    src_d        = src_q;
    ins_d        = ins_q;
    elem_d       = elem_q;
    dir_up_d     = dir_up_q;
    reading_d    = reading_q;
    pend_d       = pend_q;
    res_valid_d  = 1'b0;
    res_mem_d    = res_mem_q;
    res_status_d = res_status_q;
    res_last_d   = res_last_q;
    mem_req      = '0;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (item_i.command)
            CMD_ADD: begin
              if (add_bad || full) begin
                res_valid_d  = 1'b1;
                res_mem_d    = 1'b0;
                res_status_d = add_bad ? STAT_INVALID : STAT_FULL;
                res_last_d   = 1'b1;
              end else begin
                count_d = count_q + CntW'(1);
                if (pos_ext == (cnt_ext + CmpW'(1))) begin
                  // append: no entry moves
                  mem_req.we    = 1'b1;
                  mem_req.waddr = pos_idx;
                  mem_req.wdata = item_i.element;
                end else begin
                  state_d   = S_SHIFT;
                  dir_up_d  = 1'b1;
                  cur_d     = last_idx;
                  stop_d    = pos_idx;
                  ins_d     = pos_idx;
                  elem_d    = item_i.element;
                  reading_d = 1'b1;
                  pend_d    = 1'b0;
                end
              end
            end
            CMD_DELETE: begin
              if (rng_bad) begin
                res_valid_d  = 1'b1;
                res_mem_d    = 1'b0;
                res_status_d = STAT_INVALID;
                res_last_d   = 1'b1;
              end else begin
                count_d = count_q - CntW'(1);
                if (pos_ext != cnt_ext) begin
                  state_d   = S_SHIFT;
                  dir_up_d  = 1'b0;
                  cur_d     = AddrW'(item_i.position);
                  stop_d    = last_idx;
                  reading_d = 1'b1;
                  pend_d    = 1'b0;
                end
              end
            end
            CMD_GET: begin
              res_valid_d = 1'b1;
              res_last_d  = 1'b1;
              if (rng_bad) begin
                res_mem_d    = 1'b0;
                res_status_d = STAT_INVALID;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = pos_idx;
                res_mem_d     = 1'b1;
                res_status_d  = STAT_OK;
              end
            end
            CMD_PRINT: begin
              res_valid_d = 1'b1;
              if (count_q == '0) begin
                res_mem_d    = 1'b0;
                res_status_d = STAT_EMPTY;
                res_last_d   = 1'b1;
              end else begin
                mem_req.re    = 1'b1;
                mem_req.raddr = '0;
                res_mem_d     = 1'b1;
                res_status_d  = STAT_OK;
                res_last_d    = (count_q == CntW'(1));
                if (count_q != CntW'(1)) begin
                  state_d = S_PRINT;
                  cur_d   = AddrW'(1);
                end
              end
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end

      S_SHIFT: begin
        // write back the entry read last cycle, one place over
        if (pend_q) begin
          mem_req.we    = 1'b1;
          mem_req.waddr = dir_up_q ? (src_q + AddrW'(1)) : (src_q - AddrW'(1));
          mem_req.wdata = rdata;
        end
        // read the next entry to move
        if (reading_q) begin
          mem_req.re    = 1'b1;
          mem_req.raddr = cur_q;
          pend_d        = 1'b1;
          src_d         = cur_q;
          if (cur_q == stop_q) begin
            reading_d = 1'b0;
          end else begin
            cur_d = dir_up_q ? (cur_q - AddrW'(1)) : (cur_q + AddrW'(1));
          end
        end else begin
          pend_d = 1'b0;
        end
        // all moved: place the new element for an insert
        if (!reading_q && !pend_q) begin
          state_d = S_IDLE;
          if (dir_up_q) begin
            mem_req.we    = 1'b1;
            mem_req.waddr = ins_q;
            mem_req.wdata = elem_q;
          end
        end
      end

      S_PRINT: begin
        // one entry read per cycle, emitted the cycle after
        mem_req.re    = 1'b1;
        mem_req.raddr = cur_q;
        res_valid_d   = 1'b1;
        res_mem_d     = 1'b1;
        res_status_d  = STAT_OK;
        res_last_d    = (cur_q == last_idx);
        if (cur_q == last_idx) begin
          state_d = S_IDLE;
        end else begin
          cur_d = cur_q + AddrW'(1);
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state and registered result controls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      count_q      <= '0;
      cur_q        <= '0;
      stop_q       <= '0;
      src_q        <= '0;
      ins_q        <= '0;
      elem_q       <= '0;
      dir_up_q     <= 1'b0;
      reading_q    <= 1'b0;
      pend_q       <= 1'b0;
      res_valid_q  <= 1'b0;
      res_mem_q    <= 1'b0;
      res_status_q <= STAT_OK;
      res_last_q   <= 1'b0;
    end else begin
      state_q      <= state_d;
      count_q      <= count_d;
      cur_q        <= cur_d;
      stop_q       <= stop_d;
      src_q        <= src_d;
      ins_q        <= ins_d;
      elem_q       <= elem_d;
      dir_up_q     <= dir_up_d;
      reading_q    <= reading_d;
      pend_q       <= pend_d;
      res_valid_q  <= res_valid_d;
      res_mem_q    <= res_mem_d;
      res_status_q <= res_status_d;
      res_last_q   <= res_last_d;
    end
  end

  // outputs
  assign busy         = (state_q != S_IDLE);
  assign res_valid_o  = res_valid_q;
  assign res_o.value  = res_mem_q ? rdata : '0;
  assign res_o.status = res_status_q;
  assign res_o.last   = res_last_q;

  // checks
  `RCL_ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CntW'(CAPACITY), "count above capacity")
  `RCL_ASSERT_IMPL(a_err_last, res_valid_q && (res_status_q != STAT_OK), res_last_q, "error result without last")
  `RCL_ASSERT_IMPL(a_last_idle, res_valid_q && res_last_q, state_q == S_IDLE, "busy after final result")
  `RCL_ASSERT_IMPL(a_idle_write, (state_q == S_IDLE) && mem_req.we, accept && (item_i.command == CMD_ADD), "store write while idle without add")
  `RCL_ASSERT_NEXT(a_count_hold, state_q != S_IDLE, $stable(count_q), "count changed during a move")

endmodule

`default_nettype wire
